[design/dq_pkg.sv]
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_COLLECT
    } fsm_state_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_back;   // push at front: every entry moves one cell toward the rear
        logic shift_fwd;    // pop at front: every entry moves one cell toward the front
        logic load_sel;     // push at rear: the selected cell takes the pushed value
        logic capture_sel;  // pop at rear: the selected cell puts its entry on the read bus
    } cell_ctrl_t;

endpackage

[design/dq_cell.sv]
module dq_cell #(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                aclk,
    input  dq_pkg::cell_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]    sel_index,
    input  dq_pkg::value_t      push_value,
    input  dq_pkg::value_t      front_data,  // entry of the neighbor nearer the front
    input  dq_pkg::value_t      rear_data,   // entry of the neighbor nearer the rear
    input  dq_pkg::value_t      rear_bus,    // read bus from the neighbor nearer the rear
    output dq_pkg::value_t      data_out,
    output dq_pkg::value_t      bus_out
);
    import dq_pkg::*;

    value_t data_reg;
    value_t data_next;
    value_t bus_reg;
    value_t bus_next;
    logic   hit;

    assign hit = (sel_index == IDX_W'(CELL_INDEX));

    always_comb begin
        priority if (ctrl.shift_back) begin
            data_next = front_data;
        end else if (ctrl.shift_fwd) begin
            data_next = rear_data;
        end else if (ctrl.load_sel && hit) begin
            data_next = push_value;
        end else begin
            data_next = data_reg;
        end
    end

    // The read bus moves one cell toward the front every cycle, so a captured
    // rear entry is carried down the chain to cell zero.
    always_comb begin
        if (ctrl.capture_sel) begin
            bus_next = hit ? data_reg : '0;
        end else begin
            bus_next = rear_bus;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        bus_reg  <= bus_next;
    end

    assign data_out = data_reg;
    assign bus_out  = bus_reg;

endmodule

[design/circular_deque.sv]
// Double-ended queue of DEPTH signed 32-bit entries, held in a row of cells with
// the front entry always in cell zero. Each input item carries an operation (push
// rear, push front, pop front, pop rear) and a value; each gives exactly one
// result with status, popped value and occupancy after the operation (reported
// modulo 32). A push to a full queue or a pop from an empty one is refused and
// changes nothing. Pushes and pops at the front can follow back to back while
// the output is not stalled. A pop at the rear is read out through the cell
// chain one cell per cycle, and no item is accepted until its result has been
// registered.
module circular_deque #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: operation [1:0], push_value [33:2], zero pad [39:34]
    input  logic [dq_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: status [1:0], popped_value [33:2], occupancy [38:34], zero [39]
    output logic [dq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    steps_reg, steps_next;
    logic                m_valid_reg, m_valid_next;
    status_t             status_reg, status_next;
    value_t              popped_reg, popped_next;
    logic [CNT_W-1:0]    occ_count_reg, occ_count_next;

    cell_ctrl_t          ctrl;
    logic [IDX_W-1:0]    sel_index;
    logic [IDX_W-1:0]    rear_idx;
    logic                accept;
    logic                full;
    logic                empty;
    op_t                 op;
    value_t              push_value;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    value_t              cell_data [DEPTH];
    value_t              cell_bus  [DEPTH];

    assign op         = op_t'(s_tdata[OP_W-1:0]);
    assign push_value = s_tdata[OP_W+VALUE_W-1:OP_W];
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign rear_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign sel_index  = (op == OP_POP_REAR) ? rear_idx : count_reg[IDX_W-1:0];

    assign s_tready = (state_reg == FSM_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        value_t front_in;
        value_t rear_in;
        value_t bus_in;

        if (i == 0) begin : g_first
            assign front_in = push_value;
        end else begin : g_mid_front
            assign front_in = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign rear_in = '0;
            assign bus_in  = '0;
        end else begin : g_mid_rear
            assign rear_in = cell_data[i+1];
            assign bus_in  = cell_bus[i+1];
        end

        dq_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .sel_index  (sel_index),
            .push_value (push_value),
            .front_data (front_in),
            .rear_data  (rear_in),
            .rear_bus   (bus_in),
            .data_out   (cell_data[i]),
            .bus_out    (cell_bus[i])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        status_next    = status_reg;
        popped_next    = popped_reg;
        occ_count_next = occ_count_reg;
        ctrl           = '0;

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    status_next  = ST_DONE;
                    popped_next  = '0;
                    m_valid_next = 1'b1;
                    unique case (op)
                        OP_PUSH_REAR: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.load_sel = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.shift_back = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ctrl.shift_fwd = 1'b1;
                                popped_next    = cell_data[0];
                                count_next     = count_reg - CNT_W'(1);
                            end
                        end
                        OP_POP_REAR: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ctrl.capture_sel = 1'b1;
                                count_next       = count_reg - CNT_W'(1);
                                steps_next       = rear_idx;
                                m_valid_next     = 1'b0;
                                state_next       = FSM_COLLECT;
                            end
                        end
                        default: begin
                            status_next = ST_DONE;
                        end
                    endcase
                    occ_count_next = count_next;
                end
            end
            FSM_COLLECT: begin
                if (steps_reg == '0) begin
                    popped_next  = cell_bus[0];
                    m_valid_next = 1'b1;
                    state_next   = FSM_IDLE;
                end else begin
                    steps_next = steps_reg - IDX_W'(1);
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg     <= steps_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
        occ_count_reg <= occ_count_next;
    end

    assign occ_wide = {{OCC_W{1'b0}}, occ_count_reg};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, occ_wide[OCC_W-1:0], popped_reg, status_reg};

endmodule

[design/dq_checker.sv]
module dq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dq_pkg::*;

    logic [STATUS_W-1:0] m_status;
    value_t              m_popped;
    logic [OCC_W-1:0]    m_occ;

    assign m_status = m_tdata[STATUS_W-1:0];
    assign m_popped = m_tdata[STATUS_W+VALUE_W-1:STATUS_W];
    assign m_occ    = m_tdata[STATUS_W+VALUE_W+OCC_W-1:STATUS_W+VALUE_W];

    // No result is left over from before a reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A refused operation never hands out a value.
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == ST_FULL || m_status == ST_EMPTY) |-> m_popped == '0)
        else $error("refused operation returned a nonzero value");

    // A pop refused for lack of entries leaves the queue empty.
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_status == ST_EMPTY |-> m_occ == '0)
        else $error("empty refusal with nonzero occupancy");

    // No item is taken in while a result waits on a stalled output.
    a_no_accept_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result register is blocked");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind circular_deque dq_checker u_dq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/circular_deque_tb.sv]
module circular_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 950;
    localparam int STALL_LIMIT  = 1000;
    localparam int PAD_W        = S_TDATA_W - OP_W - VALUE_W;

    typedef struct packed {
        status_t          status;
        value_t           popped;
        logic [OCC_W-1:0] occ;
    } deque_result_t;

    // A pinned entry carries a result typed into the directed table; it replaces
    // the predicted one for that item.
    typedef struct packed {
        logic          pinned;
        deque_result_t res;
    } pin_t;

    typedef struct {
        op_t              op;
        value_t           val;
        int               reps;
        logic             pinned;
        status_t          status;
        logic [OCC_W-1:0] occ;
    } dir_row_t;

    localparam int DIR_ROWS = 12;

    // Rows that push several items add the repetition number to the value.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1, 1'b1, ST_EMPTY, 5'd0},
        '{OP_POP_REAR,   32'h0000_0000, 1, 1'b1, ST_EMPTY, 5'd0},
        '{OP_PUSH_REAR,  32'h7FFF_FFFF, 1, 1'b1, ST_DONE,  5'd1},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1, ST_DONE,  5'd2},
        '{OP_POP_REAR,   32'h0000_0000, 1, 1'b0, ST_DONE,  5'd0},
        '{OP_POP_FRONT,  32'hFFFF_FFFF, 1, 1'b0, ST_DONE,  5'd0},
        '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 8, 1'b0, ST_DONE,  5'd0},
        '{OP_PUSH_REAR,  32'h5A5A_5A5A, 8, 1'b0, ST_DONE,  5'd0},
        '{OP_PUSH_REAR,  32'hFFFF_FFFF, 1, 1'b1, ST_FULL,  5'd16},
        '{OP_PUSH_FRONT, 32'h0000_0000, 1, 1'b1, ST_FULL,  5'd16},
        '{OP_POP_REAR,   32'h0000_0000, 1, 1'b0, ST_DONE,  5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1, 1'b0, ST_DONE,  5'd0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    circular_deque #(
        .DEPTH (DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Predictor state: its own copy of the store, the two indices and the count.
    value_t deque_store [DEPTH];
    int     head_ix = 0;
    int     tail_ix = 0;
    int     fill    = 0;

    deque_result_t expected_results [$];
    pin_t          pin_q [$];

    logic idle_on = 1'b1;
    int   errors  = 0;
    int   n_items = 0;
    int   n_full  = 0;
    int   n_empty = 0;
    int   n_rear_pops = 0;
    int   quiet_cycles = 0;

    function automatic deque_result_t deque_apply(op_t op, value_t v);
        deque_result_t r;
        r.status = ST_DONE;
        r.popped = '0;
        if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
            if (fill >= DEPTH) begin
                r.status = ST_FULL;
            end else if (op == OP_PUSH_REAR) begin
                deque_store[tail_ix] = v;
                tail_ix = (tail_ix + 1) % DEPTH;
                fill++;
            end else begin
                head_ix = (head_ix + DEPTH - 1) % DEPTH;
                deque_store[head_ix] = v;
                fill++;
            end
        end else begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
                r.popped = deque_store[head_ix];
                head_ix = (head_ix + 1) % DEPTH;
                fill--;
            end else begin
                tail_ix = (tail_ix + DEPTH - 1) % DEPTH;
                r.popped = deque_store[tail_ix];
                fill--;
            end
        end
        r.occ = OCC_W'(fill);
        return r;
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic drive_item(op_t op, value_t v, logic pinned, deque_result_t res);
        int   gap;
        pin_t pin;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pin.pinned = pinned;
        pin.res    = res;
        pin_q.push_back(pin);
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, v, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // Both handshakes are sampled here, so the expectation of an item is always
    // queued before its result can be checked.
    always @(posedge aclk) begin : monitor
        deque_result_t want;
        deque_result_t got;
        pin_t          pin;
        logic          moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = deque_apply(op_t'(s_tdata[OP_W-1:0]),
                                   value_t'(s_tdata[OP_W+VALUE_W-1:OP_W]));
                if (pin_q.size() != 0) begin
                    pin = pin_q.pop_front();
                    if (pin.pinned) begin
                        want = pin.res;
                    end
                end
                expected_results.push_back(want);
                if (op_t'(s_tdata[OP_W-1:0]) == OP_POP_REAR) begin
                    n_rear_pops++;
                end
                n_items++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[STATUS_W-1:0]);
                got.popped = value_t'(m_tdata[STATUS_W+VALUE_W-1:STATUS_W]);
                got.occ    = m_tdata[STATUS_W+VALUE_W+OCC_W-1:STATUS_W+VALUE_W];
                if (got.status == ST_FULL) n_full++;
                if (got.status == ST_EMPTY) n_empty++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.popped !== want.popped) begin
                        $display("%0t: popped_value expected %0d actual %0d",
                                 $time, want.popped, got.popped);
                        errors++;
                    end
                    if (got.occ !== want.occ) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, got.occ);
                        errors++;
                    end
                end
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        deque_result_t typed_res;
        op_t           op;
        int            sent;
        int            burst;
        int            mode;
        int            push_pct;
        logic          paused;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            typed_res.status = dir_table[i].status;
            typed_res.popped = '0;
            typed_res.occ    = dir_table[i].occ;
            for (int r = 0; r < dir_table[i].reps; r++) begin
                drive_item(dir_table[i].op, dir_table[i].val + r,
                           dir_table[i].pinned, typed_res);
            end
        end

        // Bursts lean toward filling, draining or neither, so both the full and
        // the empty boundary are crossed many times with random contents.
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst   = $urandom_range(20, 60);
            mode    = $urandom_range(0, 2);
            idle_on = ($urandom_range(0, 2) != 0);
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                end else begin
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
                end
                drive_item(op, pick_value(), 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (2 * DEPTH + 8) @(posedge aclk);

        $display("Ran %0d operations: %0d pushes refused on a full deque, %0d pops refused",
                 n_items, n_full, n_empty);
        $display("on an empty deque, %0d pops at the rear.", n_rear_pops);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
design/dq_pkg.sv
design/dq_cell.sv
design/circular_deque.sv
design/dq_checker.sv
tb/circular_deque_tb.sv
